### hw/rtl/metaball_field_evaluator_defines.svh
// ============================================================================
// Metaball field evaluator assertion macros
// Shared assertion helpers for the field evaluator RTL.
// ============================================================================
`ifndef METABALL_FIELD_EVALUATOR_DEFINES_SVH
`define METABALL_FIELD_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Checks that a condition holds at every clock edge outside reset.
`define MFE_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// Checks that a trigger implies a consequence in the same cycle.
`define MFE_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define MFE_ASSERT(label, cond)
`define MFE_IMPLY(label, ante, cons)
`endif

`endif

### hw/rtl/mfe_pkg.sv
// ============================================================================
// Metaball field evaluator package
// Widths, constants, register indexes and the queue entry type.
// ============================================================================
package mfe_pkg;

  localparam int NUM_BLOB_REGS  = 4;
  localparam int DEF_BLOB_COUNT = 4;
  localparam int NUM_WALLS      = 6;
  localparam int COORD_W        = 16;
  localparam int POS_W          = 48;
  localparam int ENERGY_W       = 16;
  localparam int BLOB_D_W       = 34;
  localparam int WALL_D_W       = 32;
  localparam int FIELD_W        = 32;
  localparam int DIV_STEPS      = 32;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_INDEX_W    = 4;
  localparam logic signed [16:0] WALL_Q88 = 17'sd1728;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BLOB0_POS    = 4'd0,
    REG_BLOB1_POS    = 4'd1,
    REG_BLOB2_POS    = 4'd2,
    REG_BLOB3_POS    = 4'd3,
    REG_BLOB0_ENERGY = 4'd4,
    REG_BLOB1_ENERGY = 4'd5,
    REG_BLOB2_ENERGY = 4'd6,
    REG_BLOB3_ENERGY = 4'd7
  } cfg_reg_t;

  // Squared distances of one sample point, handed from front to back.
  typedef struct packed {
    logic [NUM_BLOB_REGS-1:0][BLOB_D_W-1:0] blob_d;
    logic [NUM_WALLS-1:0][WALL_D_W-1:0]     wall_d;
  } dist_entry_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### hw/rtl/mfe_front.sv
// ============================================================================
// Metaball field evaluator front end
// Accepts sample points and computes the ten squared distances.
// ============================================================================
module mfe_front import mfe_pkg::*; (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_W-1:0]              point_x,
  input  logic signed [COORD_W-1:0]              point_y,
  input  logic signed [COORD_W-1:0]              point_z,
  input  logic [NUM_BLOB_REGS-1:0][POS_W-1:0]    blob_pos,
  input  queue_status_t                          q_status,
  output logic                                   q_push,
  output dist_entry_t                            q_data
);

  logic en;
  logic v1, v2, v3;
  logic signed [COORD_W-1:0] pt [3];
  logic [NUM_BLOB_REGS-1:0][2:0][15:0] bmag;
  logic [NUM_WALLS-1:0][15:0]          wmag;
  logic [NUM_BLOB_REGS-1:0][2:0][31:0] bsq;
  logic [NUM_WALLS-1:0][31:0]          wsq;
  logic [NUM_BLOB_REGS-1:0][2:0][15:0] bmag_next;
  logic [NUM_WALLS-1:0][15:0]          wmag_next;

  // The pipeline moves unless the last stage holds a request the queue cannot take.
  assign en       = !(v3 && q_status.full);
  assign in_stall = !en;
  assign q_push   = v3 && !q_status.full;

  assign pt[0] = point_x;
  assign pt[1] = point_y;
  assign pt[2] = point_z;

  // Absolute coordinate differences to blob centres and to the walls.
  always_comb begin
    logic signed [16:0] d;
    for (int i = 0; i < NUM_BLOB_REGS; i++) begin
      for (int k = 0; k < 3; k++) begin
        d = 17'(pt[k]) - 17'($signed(blob_pos[i][16*k +: 16]));
        bmag_next[i][k] = d[16] ? 16'(-d) : d[15:0];
      end
    end
    for (int k = 0; k < 3; k++) begin
      d = 17'(pt[k]) - WALL_Q88;
      wmag_next[2*k] = d[16] ? 16'(-d) : d[15:0];
      d = 17'(pt[k]) + WALL_Q88;
      wmag_next[2*k+1] = d[16] ? 16'(-d) : d[15:0];
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Differences, squares, then sums.
  always_ff @(posedge clk) begin
    if (en) begin
      bmag <= bmag_next;
      wmag <= wmag_next;
      for (int i = 0; i < NUM_BLOB_REGS; i++) begin
        for (int k = 0; k < 3; k++) begin
          bsq[i][k] <= bmag[i][k] * bmag[i][k];
        end
      end
      for (int w = 0; w < NUM_WALLS; w++) begin
        wsq[w] <= wmag[w] * wmag[w];
      end
      for (int i = 0; i < NUM_BLOB_REGS; i++) begin
        q_data.blob_d[i] <= 34'(bsq[i][0]) + 34'(bsq[i][1]) + 34'(bsq[i][2]);
      end
      q_data.wall_d <= wsq;
    end
  end

endmodule

### hw/rtl/mfe_queue.sv
// ============================================================================
// Metaball field evaluator distance queue
// Short FIFO that decouples the front end from the divider back end.
// ============================================================================
`include "metaball_field_evaluator_defines.svh"

module mfe_queue import mfe_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dist_entry_t   push_data,
  input  logic          pop,
  output dist_entry_t   pop_data,
  output queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dist_entry_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign status.full  = (count == (PTR_W+1)'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_data     = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `MFE_IMPLY(a_no_push_full, push, !status.full)
  `MFE_IMPLY(a_no_pop_empty, pop, !status.empty)
  `MFE_ASSERT(a_count_range, count <= (PTR_W+1)'(DEPTH))
  `MFE_IMPLY(a_count_step, $past(push && !pop) && !$past(rst), count == $past(count) + 1'b1)

endmodule

### hw/rtl/mfe_div.sv
// ============================================================================
// Metaball field evaluator divider
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module mfe_div import mfe_pkg::*; #(
  parameter int DEN_W = WALL_D_W
) (
  input  logic               clk,
  input  logic               en,
  input  logic [DEN_W-1:0]   hi,
  input  logic [DIV_STEPS-1:0] lo,
  input  logic [DEN_W-1:0]   den,
  output logic [DIV_STEPS-1:0] quot
);

  logic [DEN_W-1:0]     rem   [DIV_STEPS+1];
  logic [DEN_W-1:0]     dv    [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] lo_s  [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_s   [DIV_STEPS+1];

  assign rem[0]  = hi;
  assign dv[0]   = den;
  assign lo_s[0] = lo;
  assign q_s[0]  = '0;
  assign quot    = q_s[DIV_STEPS];

  // Each stage shifts in one dividend bit and subtracts when it can.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;
    assign t  = {rem[k], lo_s[k][DIV_STEPS-1-k]};
    assign ge = (t >= {1'b0, dv[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? DEN_W'(t - {1'b0, dv[k]}) : t[DEN_W-1:0];
        dv[k+1]   <= dv[k];
        lo_s[k+1] <= lo_s[k];
        q_s[k+1]  <= {q_s[k][DIV_STEPS-2:0], ge};
      end
    end
  end

endmodule

### hw/rtl/mfe_back.sv
// ============================================================================
// Metaball field evaluator back end
// Divides each term, sums them and saturates the field value.
// ============================================================================
module mfe_back import mfe_pkg::*; #(
  parameter int BLOB_COUNT = DEF_BLOB_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  queue_status_t                         q_status,
  input  dist_entry_t                           q_data,
  output logic                                  q_pop,
  input  logic [NUM_BLOB_REGS-1:0][ENERGY_W-1:0] blob_energy,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [FIELD_W-1:0]                    field_value,
  output logic                                  saturated
);

  logic                 en;
  logic                 v0;
  dist_entry_t          d0;
  logic                 sat0;
  logic [DIV_STEPS-1:0] v_pipe;
  logic [DIV_STEPS-1:0] sat_pipe;
  logic [BLOB_COUNT-1:0][FIELD_W-1:0] bq;
  logic [NUM_WALLS-1:0][FIELD_W-1:0]  wq;
  logic                 v1;
  logic                 sat1;
  logic [FIELD_W+1:0]   bsum;
  logic [FIELD_W+2:0]   wsum;
  logic [FIELD_W+1:0]   bsum_next;
  logic [FIELD_W+2:0]   wsum_next;
  logic [FIELD_W+3:0]   total;

  // The whole pipeline holds while the output request is stalled.
  assign en    = !(out_valid && out_stall);
  assign q_pop = en && !q_status.empty;

  // Zero distance or a quotient of 2^32 or more saturates the term.
  always_comb begin
    sat0 = 1'b0;
    for (int i = 0; i < BLOB_COUNT; i++) begin
      if (d0.blob_d[i] == '0 ||
          d0.blob_d[i] <= BLOB_D_W'(blob_energy[i][ENERGY_W-1:8])) begin
        sat0 = 1'b1;
      end
    end
    for (int w = 0; w < NUM_WALLS; w++) begin
      if (d0.wall_d[w] <= WALL_D_W'(1)) begin
        sat0 = 1'b1;
      end
    end
  end

  // Valid and saturation travel alongside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v_pipe    <= '0;
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0        <= q_pop;
      v_pipe    <= {v_pipe[DIV_STEPS-2:0], v0};
      v1        <= v_pipe[DIV_STEPS-1];
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0       <= q_data;
      sat_pipe <= {sat_pipe[DIV_STEPS-2:0], sat0};
    end
  end

  // Blob terms: energy times 2^24 over the squared distance.
  for (genvar i = 0; i < BLOB_COUNT; i++) begin : g_blob
    mfe_div #(.DEN_W(BLOB_D_W)) u_div (
      .clk  (clk),
      .en   (en),
      .hi   (BLOB_D_W'(blob_energy[i][ENERGY_W-1:8])),
      .lo   ({blob_energy[i][7:0], 24'd0}),
      .den  (d0.blob_d[i]),
      .quot (bq[i])
    );
  end

  // Wall terms: 2^32 over the squared distance.
  for (genvar w = 0; w < NUM_WALLS; w++) begin : g_wall
    mfe_div #(.DEN_W(WALL_D_W)) u_div (
      .clk  (clk),
      .en   (en),
      .hi   (WALL_D_W'(1)),
      .lo   ('0),
      .den  (d0.wall_d[w]),
      .quot (wq[w])
    );
  end

  // Partial sums of blob and wall terms.
  always_comb begin
    bsum_next = '0;
    for (int i = 0; i < BLOB_COUNT; i++) begin
      bsum_next = bsum_next + (FIELD_W+2)'(bq[i]);
    end
    wsum_next = '0;
    for (int w = 0; w < NUM_WALLS; w++) begin
      wsum_next = wsum_next + (FIELD_W+3)'(wq[w]);
    end
  end

  assign total = (FIELD_W+4)'(bsum) + (FIELD_W+4)'(wsum);

  // Final add, saturation and output register.
  always_ff @(posedge clk) begin
    if (en) begin
      bsum        <= bsum_next;
      wsum        <= wsum_next;
      sat1        <= sat_pipe[DIV_STEPS-1];
      saturated   <= sat1 || (total[FIELD_W+3:FIELD_W] != '0);
      field_value <= (sat1 || (total[FIELD_W+3:FIELD_W] != '0)) ?
                     '1 : total[FIELD_W-1:0];
    end
  end

endmodule

### hw/rtl/metaball_field_evaluator.sv
// Metaball field evaluator.
// Send one sample point (point_x/y/z, signed Q8.8) per request on the input
// channel: it is taken when in_valid is high and in_stall is low. Each point
// gives one result on the output channel, field_value in unsigned Q16.16 and
// saturated, taken when out_valid is high and out_stall is low.
// With no stalls, the path from the accepting edge to out_valid runs through
// three register stages of distance math (the first loads at the accepting
// edge), one through the queue, one operand stage, 32 stages of the pipelined
// dividers (one quotient bit per stage) and two of summing, 39 stages in all.
// Without stalls: one point per cycle, set by the fully pipelined dividers.
// When the receiver stalls, the back end holds; the front end keeps accepting
// until the four-entry queue fills, then stalls input.
// Blob centres and energies are written through the cfg port (always ready);
// write them only while no point is in flight. Reset clears the pipeline
// valid bits and the configuration registers to zero.
// ============================================================================
// Metaball field evaluator top level
// Configuration registers, front end, queue and back end.
// ============================================================================
module metaball_field_evaluator import mfe_pkg::*; #(
  parameter int BLOB_COUNT = DEF_BLOB_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic signed [COORD_W-1:0]  point_z,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [FIELD_W-1:0]         field_value,
  output logic                       saturated,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [POS_W-1:0]           cfg_data
);

  logic [NUM_BLOB_REGS-1:0][POS_W-1:0]    blob_pos;
  logic [NUM_BLOB_REGS-1:0][ENERGY_W-1:0] blob_energy;
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  dist_entry_t   push_data;
  dist_entry_t   pop_data;

  assign cfg_ready = 1'b1;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      blob_pos    <= '0;
      blob_energy <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BLOB0_POS:    blob_pos[0]    <= cfg_data;
        REG_BLOB1_POS:    blob_pos[1]    <= cfg_data;
        REG_BLOB2_POS:    blob_pos[2]    <= cfg_data;
        REG_BLOB3_POS:    blob_pos[3]    <= cfg_data;
        REG_BLOB0_ENERGY: blob_energy[0] <= cfg_data[ENERGY_W-1:0];
        REG_BLOB1_ENERGY: blob_energy[1] <= cfg_data[ENERGY_W-1:0];
        REG_BLOB2_ENERGY: blob_energy[2] <= cfg_data[ENERGY_W-1:0];
        REG_BLOB3_ENERGY: blob_energy[3] <= cfg_data[ENERGY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .blob_pos (blob_pos),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  mfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  mfe_back #(.BLOB_COUNT(BLOB_COUNT)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .q_data      (pop_data),
    .q_pop       (q_pop),
    .blob_energy (blob_energy),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_value (field_value),
    .saturated   (saturated)
  );

endmodule
